// ----- rtl/core/smq_pkg.sv -----
// ----------------------------------------------------------------------------
// smq_pkg: shared types and constants of the selective message queue
// Word layouts for the request and response channels, the stored queue entry,
// the control bundle that goes to each cell, and the status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package smq_pkg;

   // payload word is fixed at 64 bits, eight bytes
   localparam int PAYLOAD_BYTES = 8;

   // opcodes
   localparam logic OP_SEND = 1'b0;
   localparam logic OP_RECV = 1'b1;

   // status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_LARGE = 3'd2;
   localparam logic [2:0] ST_NONE  = 3'd3;
   localparam logic [2:0] ST_RETRY = 3'd4;

   typedef struct packed {
      logic        opcode;
      logic [31:0] sender_id;
      logic [31:0] receiver_id;
      logic [31:0] msg_flags;
      logic [7:0]  payload_size;
      logic [63:0] payload_word;
      logic [47:0] send_time;
      logic        wait_wanted;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] got_sender;
      logic [31:0] got_flags;
      logic [7:0]  got_size;
      logic [63:0] got_payload;
      logic [47:0] got_time;
   } rsp_type;

   // one stored message
   typedef struct packed {
      logic [31:0] sender_id;
      logic [31:0] receiver_id;
      logic [31:0] msg_flags;
      logic [7:0]  payload_size;
      logic [63:0] payload_word;
      logic [47:0] send_time;
   } entry_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic        push;
      logic        pop;
      logic [31:0] key;
      entry_type   entry;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/core/smq_cell.sv -----
// ----------------------------------------------------------------------------
// smq_cell: one place of the message chain
// Holds one entry. Live cells sit packed from the head of the chain. A send
// fills the first empty cell; a receive removes the oldest matching cell and
// every younger cell takes its neighbor's word, closing the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module smq_cell
   import smq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire logic         prev_valid,  // older neighbor is live
   input  wire logic         found_in,    // an older cell already matched
   input  wire logic         nxt_valid,   // younger neighbor
   input  wire entry_type    nxt_entry,
   output logic              valid,
   output entry_type         entry,
   output logic              found_out,
   output entry_type         sel_entry    // this cell's entry if it is the hit
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      hit;
   logic      take_next;
   logic      load_new;

   // match and chain control
   assign hit       = valid_ff && (entry_ff.receiver_id == cmd.key);
   assign found_out = found_in || hit;
   assign take_next = cmd.pop && found_out;
   assign load_new  = cmd.push && !valid_ff && prev_valid;
   assign sel_entry = (hit && !found_in) ? entry_ff : '0;

   // next contents
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (take_next) begin
         valid_in = nxt_valid;
         entry_in = nxt_entry;
      end else if (load_new) begin
         valid_in = 1'b1;
         entry_in = cmd.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/core/selective_message_queue_top.sv -----
// ----------------------------------------------------------------------------
// selective_message_queue_top: mailbox queue with receive by destination
// Flow: an accepted word is held in the request register, the cell chain is
// searched from it, and the response register and strobe are loaded from the
// result; busy stays high for one cycle meanwhile. No new word is taken while
// busy is high, so each word finishes its single compare-and-shift pass first.
// Reset empties the queue; response side must take each strobe, unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_message_queue_top
   import smq_pkg::*;
#(
   parameter int QUEUE_DEPTH       = 16,
   parameter int MAX_PAYLOAD_BYTES = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   req_type      req_ff;
   logic         busy_ff;
   logic         rsp_strobe_ff;
   rsp_type      rsp_ff, rsp_in;
   cell_cmd_type cmd;

   logic      valid_chain [QUEUE_DEPTH+1];
   logic      found_chain [QUEUE_DEPTH+1];
   entry_type entry_chain [QUEUE_DEPTH+1];
   entry_type sel_entry   [QUEUE_DEPTH];
   entry_type hit_entry;

   logic        full;
   logic        too_large;
   logic        found;
   logic [63:0] kept_payload;

   // request capture
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= start && !busy_ff;
      end
   end

   // only the first payload_size bytes are kept
   always_comb begin
      kept_payload = '0;
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
         if (8'(b) < req_ff.payload_size) begin
            kept_payload[b*8 +: 8] = req_ff.payload_word[b*8 +: 8];
         end
      end
   end

   assign full      = valid_chain[QUEUE_DEPTH-1];
   assign too_large = req_ff.payload_size > 8'(MAX_PAYLOAD_BYTES);
   assign found     = found_chain[QUEUE_DEPTH];

   // chain command
   always_comb begin
      cmd.push                = busy_ff && (req_ff.opcode == OP_SEND) && !full && !too_large;
      cmd.pop                 = busy_ff && (req_ff.opcode == OP_RECV) && found;
      cmd.key                 = req_ff.receiver_id;
      cmd.entry.sender_id     = req_ff.sender_id;
      cmd.entry.receiver_id   = req_ff.receiver_id;
      cmd.entry.msg_flags     = req_ff.msg_flags;
      cmd.entry.payload_size  = req_ff.payload_size;
      cmd.entry.payload_word  = kept_payload;
      cmd.entry.send_time     = req_ff.send_time;
   end

   // cell chain, head at index zero
   assign valid_chain[QUEUE_DEPTH] = 1'b0;
   assign entry_chain[QUEUE_DEPTH] = '0;
   assign found_chain[0]           = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic prev_valid;
      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = valid_chain[i-1];
      end

      smq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid (prev_valid),
         .found_in   (found_chain[i]),
         .nxt_valid  (valid_chain[i+1]),
         .nxt_entry  (entry_chain[i+1]),
         .valid      (valid_chain[i]),
         .entry      (entry_chain[i]),
         .found_out  (found_chain[i+1]),
         .sel_entry  (sel_entry[i])
      );
   end

   // at most one cell offers its entry
   always_comb begin
      hit_entry = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         hit_entry = hit_entry | sel_entry[i];
      end
   end

   // response word
   always_comb begin
      rsp_in = '0;
      if (req_ff.opcode == OP_SEND) begin
         if (full) begin
            rsp_in.status = ST_FULL;
         end else if (too_large) begin
            rsp_in.status = ST_LARGE;
         end else begin
            rsp_in.status = ST_OK;
         end
      end else if (found) begin
         rsp_in.status      = ST_OK;
         rsp_in.got_sender  = hit_entry.sender_id;
         rsp_in.got_flags   = hit_entry.msg_flags;
         rsp_in.got_size    = hit_entry.payload_size;
         rsp_in.got_payload = hit_entry.payload_word;
         rsp_in.got_time    = hit_entry.send_time;
      end else begin
         rsp_in.status = req_ff.wait_wanted ? ST_RETRY : ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= busy_ff;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/smq_checker.sv -----
// ----------------------------------------------------------------------------
// smq_checker: port-level checks of the selective message queue
// Watches the request and response ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smq_checker
   import smq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   // every accepted word is answered with a response strobe
   a_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted word got no response");

   // no response strobe without an accepted word before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without request");

   // busy is raised when a word is accepted
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after accept");

   // responses with a status other than OK carry no message
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |->
         (rsp_data.got_sender == '0 && rsp_data.got_flags == '0 &&
          rsp_data.got_size == '0 && rsp_data.got_payload == '0 &&
          rsp_data.got_time == '0))
      else $error("message fields set on failed response");

   // status is one of the defined codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status == ST_OK || rsp_data.status == ST_FULL ||
                      rsp_data.status == ST_LARGE || rsp_data.status == ST_NONE ||
                      rsp_data.status == ST_RETRY))
      else $error("undefined status code");

endmodule

bind selective_message_queue_top smq_checker u_smq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
